### hw/rtl/cbs_pkg.sv
// cbs_pkg: shared types, codes and helpers for the budget and deadline engine
`timescale 1ns / 1ps
package cbs_pkg;

  localparam int TASKS_DEF      = 16;
  localparam int MAX_ROUNDS_DEF = 64;

  localparam int TW  = 32;  // time and budget width
  localparam int PW  = 31;  // nominal budget and period width
  localparam int UW  = 16;  // inverse utilization width
  localparam int CW  = 20;  // min capacity width
  localparam int IDW = 4;   // task id port width

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_LOAD     = 2'd0;
  localparam mode_t MODE_ACTIVATE = 2'd1;
  localparam mode_t MODE_PREEMPT  = 2'd2;
  localparam mode_t MODE_END      = 2'd3;

  typedef logic [2:0] action_t;
  localparam action_t ACT_READY      = 3'd0;
  localparam action_t ACT_RECHARGING = 3'd1;
  localparam action_t ACT_STACKED    = 3'd2;
  localparam action_t ACT_SUSPENDED  = 3'd3;
  localparam action_t ACT_LOADED     = 3'd4;

  typedef struct packed {
    logic [TW-1:0] deadline;
    logic [TW-1:0] budget;
    logic          active;
  } dyn_t;

  typedef struct packed {
    logic [PW-1:0] budget;
    logic [PW-1:0] period;
    logic [UW-1:0] inv_util;
  } par_t;

  typedef struct packed {
    logic we_dyn;
    logic we_par;
  } tbl_wr_t;

  function automatic logic below_min(input logic [TW-1:0] bud, input logic [CW-1:0] minc);
    below_min = $signed(bud) < $signed({{(TW-CW){1'b0}}, minc});
  endfunction

  function automatic logic above_min(input logic [TW-1:0] bud, input logic [CW-1:0] minc);
    above_min = $signed(bud) > $signed({{(TW-CW){1'b0}}, minc});
  endfunction

endpackage

### hw/rtl/cbs_alu.sv
// cbs_alu: shared 32-bit add/subtract unit
`timescale 1ns / 1ps
module cbs_alu (
  input  logic [cbs_pkg::TW-1:0] a,
  input  logic [cbs_pkg::TW-1:0] b,
  input  logic                   sub,
  output logic [cbs_pkg::TW-1:0] y
);

  logic [cbs_pkg::TW-1:0] b_eff;

  assign b_eff = sub ? ~b : b;
  assign y     = a + b_eff + {{(cbs_pkg::TW-1){1'b0}}, sub};

endmodule

### hw/rtl/cbs_tbl.sv
// cbs_tbl: per-task parameter and server state memories with valid bits
`timescale 1ns / 1ps
module cbs_tbl #(
  parameter int TASKS = cbs_pkg::TASKS_DEF,
  parameter int IW    = $clog2(TASKS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [IW-1:0]        rd_idx,
  output cbs_pkg::dyn_t        rd_dyn,
  output cbs_pkg::par_t        rd_par,
  input  cbs_pkg::tbl_wr_t     wr,
  input  logic [IW-1:0]        wr_idx,
  input  cbs_pkg::dyn_t        wr_dyn,
  input  cbs_pkg::par_t        wr_par
);

  cbs_pkg::dyn_t dyn_mem [TASKS];
  cbs_pkg::par_t par_mem [TASKS];
  logic [TASKS-1:0] dyn_vld_r;
  logic [TASKS-1:0] par_vld_r;
  cbs_pkg::dyn_t dyn_q_r;
  cbs_pkg::par_t par_q_r;
  logic dyn_vq_r;
  logic par_vq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dyn_vld_r <= '0;
      par_vld_r <= '0;
    end else begin
      if (wr.we_dyn) dyn_vld_r[wr_idx] <= 1'b1;
      if (wr.we_par) par_vld_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.we_dyn) dyn_mem[wr_idx] <= wr_dyn;
    if (wr.we_par) par_mem[wr_idx] <= wr_par;
    if (rd_en) begin
      dyn_q_r  <= dyn_mem[rd_idx];
      par_q_r  <= par_mem[rd_idx];
      dyn_vq_r <= dyn_vld_r[rd_idx];
      par_vq_r <= par_vld_r[rd_idx];
    end
  end

  // entries never written read as zero
  assign rd_dyn = dyn_vq_r ? dyn_q_r : '0;
  assign rd_par = par_vq_r ? par_q_r : '0;

endmodule

### hw/rtl/cbs_budget_deadline_engine.sv
// cbs_budget_deadline_engine: constant bandwidth server budget and deadline engine
//
//   channel  | ports                                   | timing
//   ---------+-----------------------------------------+------------------------------
//   request  | start, busy, in_*                       | taken when start & !busy
//   result   | out_valid, out_*                        | one-cycle strobe, no stall
//   config   | cfg_we, cfg_wdata                       | written when cfg_we
//
// load passes through the read, difference and done states; activate, preempt
// and end take more adder steps, and a recharge repeats its check and move
// states for at most MAX_ROUNDS rounds. every time and budget add and subtract
// goes through one shared 32-bit adder. busy stays high until the cycle of the
// strobe. reset clears all tables through per-entry valid bits, so no clearing
// pass is needed.
`timescale 1ns / 1ps
module cbs_budget_deadline_engine #(
  parameter int TASKS      = cbs_pkg::TASKS_DEF,
  parameter int MAX_ROUNDS = cbs_pkg::MAX_ROUNDS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_mode,
  input  logic [cbs_pkg::IDW-1:0]       in_task_id,
  input  logic [cbs_pkg::TW-1:0]        in_now,
  input  logic [cbs_pkg::PW-1:0]        in_load_budget,
  input  logic [cbs_pkg::PW-1:0]        in_load_period,
  input  logic [cbs_pkg::UW-1:0]        in_load_inv_util,
  input  logic                          in_holds_resource,
  input  logic                          in_has_pending,
  output logic                          out_valid,
  output logic [2:0]                    out_action,
  output logic [cbs_pkg::TW-1:0]        out_new_deadline,
  output logic signed [cbs_pkg::TW-1:0] out_budget_left,
  output logic [cbs_pkg::TW-1:0]        out_timer_delay,
  output logic                          out_overrun,
  input  logic                          cfg_we,
  input  logic [cbs_pkg::CW-1:0]        cfg_wdata
);

  localparam int IW = $clog2(TASKS);
  localparam int RW = $clog2(MAX_ROUNDS + 1);
  localparam int TW = cbs_pkg::TW;
  localparam int PW = cbs_pkg::PW;
  localparam int UW = cbs_pkg::UW;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD     = 4'd1;
  localparam logic [3:0] S_DIFF   = 4'd2;
  localparam logic [3:0] S_ACC    = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_SLACK  = 4'd5;
  localparam logic [3:0] S_RESET  = 4'd6;
  localparam logic [3:0] S_RC_CHK = 4'd7;
  localparam logic [3:0] S_RC_MOV = 4'd8;
  localparam logic [3:0] S_DELAY  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state_r, state_nxt;

  cbs_pkg::mode_t   mode_r;
  logic [IW-1:0]    idx_r;
  logic [TW-1:0]    now_r;
  logic [PW-1:0]    ldb_r;
  logic [PW-1:0]    ldp_r;
  logic [UW-1:0]    ldiu_r;
  logic             holds_r;
  logic             pend_r;

  logic [TW-1:0]    dl_r;
  logic [TW-1:0]    bud_r;
  logic             act_r;
  logic [PW-1:0]    nom_r;
  logic [PW-1:0]    per_r;
  logic [UW-1:0]    iu_r;
  logic [TW-1:0]    dnow_r;
  logic [TW-1:0]    prod_r;
  logic [TW-1:0]    delay_r;
  logic [RW-1:0]    round_r;
  cbs_pkg::action_t action_r;
  logic             ovr_r;

  logic [TW-1:0]           last_r;
  logic [cbs_pkg::CW-1:0]  min_cap_r;

  logic                    out_valid_r;
  cbs_pkg::action_t        out_action_r;
  logic [TW-1:0]           out_dl_r;
  logic [TW-1:0]           out_bud_r;
  logic [TW-1:0]           out_td_r;
  logic                    out_ovr_r;

  logic [IW-1:0]      in_idx;
  logic               accept;
  logic [TW-1:0]      alu_a, alu_b, alu_y;
  logic               alu_sub;
  logic [TW+UW-1:0]   mul_full;
  logic               low;
  logic               last_round;

  cbs_pkg::dyn_t    rd_dyn, wr_dyn;
  cbs_pkg::par_t    rd_par, wr_par;
  cbs_pkg::tbl_wr_t tbl_wr;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    in_idx = '0;
    for (int i = 0; i < (1 << cbs_pkg::IDW); i++) begin
      if (in_task_id == cbs_pkg::IDW'(i)) in_idx = IW'(i % TASKS);
    end
  end

  cbs_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  assign wr_dyn        = '{deadline: dl_r, budget: bud_r, active: act_r};
  assign wr_par        = '{budget: ldb_r, period: ldp_r, inv_util: ldiu_r};
  assign tbl_wr.we_dyn = (state_r == S_DONE);
  assign tbl_wr.we_par = (state_r == S_DONE) && (mode_r == cbs_pkg::MODE_LOAD);

  cbs_tbl #(
    .TASKS (TASKS),
    .IW    (IW)
  ) u_tbl (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (accept),
    .rd_idx (in_idx),
    .rd_dyn (rd_dyn),
    .rd_par (rd_par),
    .wr     (tbl_wr),
    .wr_idx (idx_r),
    .wr_dyn (wr_dyn),
    .wr_par (wr_par)
  );

  assign mul_full   = {{UW{1'b0}}, bud_r} * {{TW{1'b0}}, iu_r};
  assign low        = cbs_pkg::below_min(alu_y, min_cap_r);
  assign last_round = (round_r == RW'(MAX_ROUNDS));

  // sequencer and shared adder operand select
  always_comb begin
    state_nxt = state_r;
    alu_a     = dl_r;
    alu_b     = now_r;
    alu_sub   = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        if (mode_r == cbs_pkg::MODE_LOAD) begin
          state_nxt = S_DONE;
        end else if (mode_r == cbs_pkg::MODE_ACTIVATE) begin
          if (!act_r || alu_y[TW-1]) state_nxt = S_RESET;
          else if (cbs_pkg::below_min(bud_r, min_cap_r)) state_nxt = S_RC_CHK;
          else state_nxt = S_MUL;
        end else begin
          alu_a     = now_r;
          alu_b     = last_r;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        alu_a = bud_r;
        alu_b = dnow_r;
        if (mode_r == cbs_pkg::MODE_PREEMPT) begin
          if (holds_r) state_nxt = S_DONE;
          else if (low) state_nxt = S_RC_CHK;
          else state_nxt = S_DONE;
        end else begin
          if (!pend_r) state_nxt = S_DONE;
          else if (low) state_nxt = S_RC_CHK;
          else state_nxt = S_DONE;
        end
      end
      S_MUL: begin
        state_nxt = S_SLACK;
      end
      S_SLACK: begin
        alu_a = dnow_r;
        alu_b = prod_r;
        if ($signed(alu_y) <= 0) state_nxt = S_RESET;
        else state_nxt = S_DONE;
      end
      S_RESET: begin
        alu_a     = now_r;
        alu_b     = {1'b0, per_r};
        alu_sub   = 1'b0;
        state_nxt = S_DONE;
      end
      S_RC_CHK: begin
        alu_a   = bud_r;
        alu_b   = {1'b0, nom_r};
        alu_sub = 1'b0;
        if ($signed(bud_r) > 0) state_nxt = S_DELAY;
        else if (cbs_pkg::above_min(alu_y, min_cap_r)) state_nxt = S_DELAY;
        else if (last_round) state_nxt = S_DELAY;
        else state_nxt = S_RC_MOV;
      end
      S_RC_MOV: begin
        alu_a     = dl_r;
        alu_b     = {1'b0, per_r};
        alu_sub   = 1'b0;
        state_nxt = S_RC_CHK;
      end
      S_DELAY: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_r      <= '0;
      min_cap_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_DONE);
      if (cfg_we) min_cap_r <= cfg_wdata;
      if (state_r == S_ACC) last_r <= now_r;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_r   <= in_mode;
          idx_r    <= in_idx;
          now_r    <= in_now;
          ldb_r    <= in_load_budget;
          ldp_r    <= in_load_period;
          ldiu_r   <= in_load_inv_util;
          holds_r  <= in_holds_resource;
          pend_r   <= in_has_pending;
          action_r <= cbs_pkg::ACT_READY;
          ovr_r    <= 1'b0;
        end
      end
      S_RD: begin
        dl_r  <= rd_dyn.deadline;
        bud_r <= rd_dyn.budget;
        act_r <= rd_dyn.active;
        nom_r <= rd_par.budget;
        per_r <= rd_par.period;
        iu_r  <= rd_par.inv_util;
      end
      S_DIFF: begin
        dnow_r <= alu_y;
        if (mode_r == cbs_pkg::MODE_LOAD) begin
          action_r <= cbs_pkg::ACT_LOADED;
        end else if (mode_r == cbs_pkg::MODE_ACTIVATE) begin
          if (state_nxt == S_RESET) act_r <= 1'b1;
          if (state_nxt == S_RC_CHK) begin
            action_r <= cbs_pkg::ACT_RECHARGING;
            round_r  <= RW'(1);
          end
        end
      end
      S_ACC: begin
        bud_r <= alu_y;
        if (state_nxt == S_RC_CHK) begin
          action_r <= cbs_pkg::ACT_RECHARGING;
          round_r  <= RW'(1);
        end else if (mode_r == cbs_pkg::MODE_PREEMPT && holds_r) begin
          action_r <= cbs_pkg::ACT_STACKED;
        end else if (mode_r == cbs_pkg::MODE_END && !pend_r) begin
          action_r <= cbs_pkg::ACT_SUSPENDED;
        end
      end
      S_MUL: begin
        prod_r <= mul_full[TW-1:0];
      end
      S_RESET: begin
        dl_r  <= alu_y;
        bud_r <= {1'b0, nom_r};
      end
      S_RC_CHK: begin
        if ($signed(bud_r) > 0) begin
          bud_r <= {1'b0, nom_r};
        end else begin
          bud_r <= alu_y;
          if (!cbs_pkg::above_min(alu_y, min_cap_r) && last_round) ovr_r <= 1'b1;
        end
      end
      S_RC_MOV: begin
        dl_r    <= alu_y;
        round_r <= round_r + RW'(1);
      end
      S_DELAY: begin
        delay_r <= alu_y;
      end
      S_DONE: begin
        out_action_r <= action_r;
        out_dl_r     <= dl_r;
        out_bud_r    <= bud_r;
        out_td_r     <= (action_r == cbs_pkg::ACT_RECHARGING) ? delay_r : '0;
        out_ovr_r    <= ovr_r;
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_action       = out_action_r;
  assign out_new_deadline = out_dl_r;
  assign out_budget_left  = $signed(out_bud_r);
  assign out_timer_delay  = out_td_r;
  assign out_overrun      = out_ovr_r;

endmodule

### hw/rtl/cbs_chk.sv
// cbs_chk: port-level checks for the budget and deadline engine, with bind
`timescale 1ns / 1ps
module cbs_chk (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic                   out_valid,
  input logic [2:0]             out_action,
  input logic [cbs_pkg::TW-1:0] out_timer_delay,
  input logic                   out_overrun
);

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but engine not busy");

  a_delay_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action != cbs_pkg::ACT_RECHARGING) |-> (out_timer_delay == '0))
    else $error("timer delay set without recharge");

  a_overrun_rc: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overrun) |-> (out_action == cbs_pkg::ACT_RECHARGING))
    else $error("overrun without recharge");

endmodule

bind cbs_budget_deadline_engine cbs_chk u_cbs_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_action      (out_action),
  .out_timer_delay (out_timer_delay),
  .out_overrun     (out_overrun)
);
